// File: rtl/core/gmt_pkg.sv
// Shared codes, defaults and types of the gossip membership table.
package gmt_pkg;

	// Default table size and counter width.
	localparam int DEF_MAX_MEMBERS = 16;
	localparam int DEF_COUNT_WIDTH = 32;

	// Configuration port layout.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic CFG_SELF_INDEX = 1'b0;
	localparam logic CFG_SUSPICION  = 1'b1;

	// Member status codes.
	localparam logic [1:0] ST_ALIVE = 2'd0;
	localparam logic [1:0] ST_SUS   = 2'd1;
	localparam logic [1:0] ST_DEAD  = 2'd2;

	// Item modes.
	localparam logic [1:0] MODE_MERGE = 2'd0;
	localparam logic [1:0] MODE_PING  = 2'd1;
	localparam logic [1:0] MODE_LEAVE = 2'd2;

	// Update decision for one table entry.
	typedef struct packed {
		logic       changed;
		logic       marked;
		logic       refuted;
		logic       self_dead;
		logic       new_valid;
		logic [1:0] new_status;
		logic       sus_we;
		logic       sus_clr;
		logic       dead_we;
		logic       dead_clr;
	} gmt_upd_t;

endpackage

// File: rtl/core/gmt_merge.sv
// Merge, ping timeout and leave rules applied to one table entry.
module gmt_merge #(
	parameter int COUNT_WIDTH = gmt_pkg::DEF_COUNT_WIDTH
) (
	input  logic [1:0]             mode,
	input  logic [1:0]             gst,
	input  logic [COUNT_WIDTH-1:0] ginc,
	input  logic                   is_self,
	input  logic                   sus_on,
	input  logic                   cur_valid,
	input  logic [1:0]             cur_status,
	input  logic [COUNT_WIDTH-1:0] cur_inc,
	output gmt_pkg::gmt_upd_t      upd,
	output logic [COUNT_WIDTH-1:0] new_inc
);
	import gmt_pkg::*;

	logic inc_lt;
	logic inc_le;
	logic inc_max;

	// Incarnation comparisons shared by the rules.
	assign inc_lt  = cur_inc < ginc;
	assign inc_le  = cur_inc <= ginc;
	assign inc_max = &cur_inc;

	// Decide the new entry contents and the flags of this item.
	always_comb begin
		upd            = '0;
		upd.new_valid  = cur_valid;
		upd.new_status = cur_status;
		new_inc        = cur_inc;
		case (mode)
			MODE_MERGE: begin
				if (!cur_valid) begin
					// A join takes alive or suspect gossip as it stands.
					if (gst == ST_ALIVE || gst == ST_SUS) begin
						upd.new_valid  = 1'b1;
						upd.new_status = gst;
						new_inc        = ginc;
						upd.sus_we     = 1'b1;
						upd.sus_clr    = !(gst == ST_SUS && sus_on);
						upd.dead_we    = 1'b1;
						upd.dead_clr   = 1'b1;
						upd.changed    = 1'b1;
						upd.marked     = 1'b1;
					end
				end else begin
					case (gst)
						ST_ALIVE: begin
							if ((cur_status == ST_ALIVE ||
								(cur_status == ST_SUS && sus_on)) && inc_lt) begin
								upd.new_status = ST_ALIVE;
								new_inc        = ginc;
								upd.changed    = 1'b1;
								upd.marked     = 1'b1;
							end
						end
						ST_DEAD: begin
							if (cur_status != ST_DEAD) begin
								upd.new_status = ST_DEAD;
								upd.dead_we    = 1'b1;
								upd.changed    = 1'b1;
								upd.marked     = 1'b1;
								upd.self_dead  = is_self;
							end
						end
						ST_SUS: begin
							if (sus_on) begin
								if (is_self) begin
									// Refute by bumping the own incarnation when it matches and is not saturated.
									if (cur_inc == ginc && !inc_max) begin
										new_inc = cur_inc + COUNT_WIDTH'(1);
									end
									upd.changed = 1'b1;
									upd.marked  = 1'b1;
									upd.refuted = 1'b1;
								end else if (cur_status == ST_SUS && inc_lt) begin
									new_inc     = ginc;
									upd.sus_we  = 1'b1;
									upd.changed = 1'b1;
									upd.marked  = 1'b1;
								end else if (cur_status == ST_ALIVE && inc_le) begin
									upd.new_status = ST_SUS;
									new_inc        = ginc;
									upd.sus_we     = 1'b1;
									upd.changed    = 1'b1;
									upd.marked     = 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			MODE_PING: begin
				// An alive target is suspected, or a live one declared dead without suspicion.
				if (cur_valid && cur_status != ST_DEAD) begin
					if (cur_status == ST_ALIVE && sus_on) begin
						upd.new_status = ST_SUS;
						upd.sus_we     = 1'b1;
						upd.changed    = 1'b1;
					end else if (!sus_on) begin
						upd.new_status = ST_DEAD;
						upd.dead_we    = 1'b1;
						upd.changed    = 1'b1;
					end
					upd.marked = 1'b1;
				end
			end
			MODE_LEAVE: begin
				if (cur_valid) begin
					upd.new_status = ST_DEAD;
					upd.dead_we    = 1'b1;
					upd.changed    = 1'b1;
					upd.marked     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/gossip_membership_table_merge.sv
// Top level of the gossip membership table with suspicion-aware merging.
// The table holds MAX_MEMBERS peers indexed by member number; each item
// does one read-modify-write of one entry. An item is taken every cycle
// while results are taken. The input stage reads the entry's incarnation from
// the table memory (with a bypass of the write of the item ahead); the rule
// stage then applies the rules and writes the entry and the result register
// together. Status, valid and gossip marks sit in flip-flops cleared at
// reset; incarnations and the suspicion and death periods sit in memories
// that need no clearing because an entry that is not valid reads as zero.
// Configuration must be written through the APB-style port only while the
// block is idle; the block itself does not enforce this.
module gossip_membership_table_merge #(
	parameter int MAX_MEMBERS = gmt_pkg::DEF_MAX_MEMBERS,
	parameter int COUNT_WIDTH = gmt_pkg::DEF_COUNT_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gmt_pkg::PADDR_W-1:0] paddr,
	input  logic [gmt_pkg::PDATA_W-1:0] pwdata,
	output logic [gmt_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// Item channel.
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [1:0]                  mode,
	input  logic [3:0]                  member_index,
	input  logic [1:0]                  entry_status,
	input  logic [31:0]                 entry_incarnation,
	input  logic [31:0]                 current_period,
	// Result channel.
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        entry_changed,
	output logic                        new_valid,
	output logic [1:0]                  new_status,
	output logic [31:0]                 new_incarnation,
	output logic                        marked_for_send,
	output logic                        self_refuted,
	output logic                        self_declared_dead
);
	import gmt_pkg::*;

	localparam int IW = $clog2(MAX_MEMBERS);
	localparam int CW = COUNT_WIDTH;

	// Configuration registers.
	logic [3:0] self_q;
	logic       susp_q;
	logic       cfg_we;

	// Table storage.
	logic          valid_q [MAX_MEMBERS];
	logic [1:0]    state_q [MAX_MEMBERS];
	logic          mark_q  [MAX_MEMBERS];
	logic [CW-1:0] inc_mem  [MAX_MEMBERS];
	logic [CW-1:0] sus_mem  [MAX_MEMBERS];
	logic [CW-1:0] dead_mem [MAX_MEMBERS];

	// Input stage.
	logic          vld_s1;
	logic [1:0]    mode_s1;
	logic [3:0]    idx_s1;
	logic [IW-1:0] addr_s1;
	logic          range_s1;
	logic [1:0]    gst_s1;
	logic [CW-1:0] ginc_s1;
	logic [CW-1:0] per_s1;
	logic [CW-1:0] inc_rd_s1;

	// Rule evaluation and write control.
	logic          in_range;
	logic [IW-1:0] in_addr;
	logic          advance;
	logic          accept;
	logic          wr_go;
	logic          cur_valid;
	logic [1:0]    cur_status;
	logic [CW-1:0] cur_inc;
	gmt_upd_t      upd;
	logic [CW-1:0] next_inc;

	// Result register.
	logic out_vld_q;

	// Configuration writes and reads; every transfer completes at once.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q <= 4'd0;
			susp_q <= 1'b1;
		end else if (cfg_we) begin
			case (paddr[2])
				CFG_SELF_INDEX: self_q <= pwdata[3:0];
				CFG_SUSPICION:  susp_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_SELF_INDEX: prdata = {{(PDATA_W-4){1'b0}}, self_q};
			CFG_SUSPICION:  prdata = {{(PDATA_W-1){1'b0}}, susp_q};
			default:        prdata = '0;
		endcase
	end

	// Handshake: the input stage moves on when the result register frees up.
	assign advance    = !out_vld_q || result_ready;
	assign item_ready = !vld_s1 || advance;
	assign accept     = item_valid && item_ready;
	assign wr_go      = vld_s1 && advance && range_s1;

	assign in_range = {28'd0, member_index} < MAX_MEMBERS;
	assign in_addr  = IW'(member_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	// Input register and incarnation read, bypassing the write of the item ahead.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			idx_s1   <= member_index;
			addr_s1  <= in_addr;
			range_s1 <= in_range;
			gst_s1   <= entry_status;
			ginc_s1  <= CW'(entry_incarnation);
			per_s1   <= CW'(current_period);
			if (wr_go && upd.changed && addr_s1 == in_addr) begin
				inc_rd_s1 <= next_inc;
			end else begin
				inc_rd_s1 <= inc_mem[in_addr];
			end
		end
	end

	// Current entry; an entry that is not valid reads as all zero.
	assign cur_valid  = valid_q[addr_s1];
	assign cur_status = cur_valid ? state_q[addr_s1] : ST_ALIVE;
	assign cur_inc    = cur_valid ? inc_rd_s1 : '0;

	gmt_merge #(
		.COUNT_WIDTH(CW)
	) u_merge (
		.mode      (mode_s1),
		.gst       (gst_s1),
		.ginc      (ginc_s1),
		.is_self   (idx_s1 == self_q),
		.sus_on    (susp_q),
		.cur_valid (cur_valid),
		.cur_status(cur_status),
		.cur_inc   (cur_inc),
		.upd       (upd),
		.new_inc   (next_inc)
	);

	// Flag and status flip-flops of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_MEMBERS; i++) begin
				valid_q[i] <= 1'b0;
				state_q[i] <= ST_ALIVE;
				mark_q[i]  <= 1'b0;
			end
		end else if (wr_go) begin
			if (upd.changed) begin
				valid_q[addr_s1] <= upd.new_valid;
				state_q[addr_s1] <= upd.new_status;
			end
			if (upd.marked) begin
				mark_q[addr_s1] <= 1'b1;
			end
		end
	end

	// Incarnation and period memories.
	always_ff @(posedge clk) begin
		if (wr_go) begin
			if (upd.changed) begin
				inc_mem[addr_s1] <= next_inc;
			end
			if (upd.sus_we) begin
				sus_mem[addr_s1] <= upd.sus_clr ? '0 : per_s1;
			end
			if (upd.dead_we) begin
				dead_mem[addr_s1] <= upd.dead_clr ? '0 : per_s1;
			end
		end
	end

	// Result register; an index beyond the table gives an all-zero result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && advance) begin
			entry_changed      <= range_s1 && upd.changed;
			new_valid          <= range_s1 && upd.new_valid;
			new_status         <= range_s1 ? upd.new_status : ST_ALIVE;
			new_incarnation    <= range_s1 ? 32'(next_inc) : 32'd0;
			marked_for_send    <= range_s1 && upd.marked;
			self_refuted       <= range_s1 && upd.refuted;
			self_declared_dead <= range_s1 && upd.self_dead;
		end
	end

	assign result_valid = out_vld_q;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the gossip membership table with suspicion-aware merging.
module testbench;
	import gmt_pkg::*;

	localparam int TABLE_DEPTH = DEF_MAX_MEMBERS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] ST_UNKNOWN  = 2'd3;

	// One gossip item as it crosses the input channel.
	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  idx;
		logic [1:0]  status;
		logic [31:0] inc;
		logic [31:0] period;
	} gossip_item_t;

	// Entry outcome as reported on the result channel.
	typedef struct packed {
		logic        changed;
		logic        valid;
		logic [1:0]  status;
		logic [31:0] inc;
		logic        marked;
		logic        refuted;
		logic        self_dead;
	} entry_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  mode = '0;
	logic [3:0]  member_index = '0;
	logic [1:0]  entry_status = '0;
	logic [31:0] entry_incarnation = '0;
	logic [31:0] current_period = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        entry_changed;
	logic        new_valid;
	logic [1:0]  new_status;
	logic [31:0] new_incarnation;
	logic        marked_for_send;
	logic        self_refuted;
	logic        self_declared_dead;

	gossip_membership_table_merge DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready), .mode(mode),
		.member_index(member_index), .entry_status(entry_status),
		.entry_incarnation(entry_incarnation), .current_period(current_period),
		.result_valid(result_valid), .result_ready(result_ready),
		.entry_changed(entry_changed), .new_valid(new_valid), .new_status(new_status),
		.new_incarnation(new_incarnation), .marked_for_send(marked_for_send),
		.self_refuted(self_refuted), .self_declared_dead(self_declared_dead)
	);

	always #5 clk = ~clk;

	// Shadow membership table and configuration.
	logic        tbl_valid [TABLE_DEPTH];
	logic [1:0]  tbl_status [TABLE_DEPTH];
	logic [31:0] tbl_inc [TABLE_DEPTH];
	logic [31:0] tbl_sus_since [TABLE_DEPTH];
	logic [31:0] tbl_dead_since [TABLE_DEPTH];
	logic        tbl_mark [TABLE_DEPTH];
	logic [3:0]  cfg_self = 4'd0;
	logic        cfg_suspicion = 1'b1;

	gossip_item_t   gossip_q [$];
	entry_outcome_t outcome_q [$];
	int queued_count = 0;
	int accepted_count = 0;
	int fail_count = 0;
	int results_checked = 0;
	int writes_seen = 0;
	int refutes_seen = 0;
	int self_deaths_seen = 0;
	int cycle_count = 0;
	logic item_fire = 1'b0;
	logic result_fire = 1'b0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	// Stimulus shaping: last incarnation gossiped per entry and a running period.
	logic [31:0] gen_inc [TABLE_DEPTH];
	logic [31:0] gen_period = 32'd1000;

	initial begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			tbl_valid[k] = 1'b0;
			tbl_status[k] = ST_ALIVE;
			tbl_inc[k] = '0;
			tbl_sus_since[k] = '0;
			tbl_dead_since[k] = '0;
			tbl_mark[k] = 1'b0;
			gen_inc[k] = '0;
		end
	end

	// Applies one item to the shadow table and returns the outcome it should report.
	function automatic entry_outcome_t merge_membership(input gossip_item_t it);
		entry_outcome_t r;
		logic [1:0] cs;
		logic [31:0] ci;
		logic sus_on;
		int i;
		r = '0;
		i = int'(it.idx);
		cs = tbl_status[i];
		ci = tbl_inc[i];
		sus_on = cfg_suspicion;
		case (it.mode)
			MODE_MERGE: begin
				if (!tbl_valid[i]) begin
					// Join; dead gossip about an unknown member is dropped.
					if (it.status == ST_ALIVE || it.status == ST_SUS) begin
						tbl_valid[i] = 1'b1;
						tbl_status[i] = it.status;
						tbl_inc[i] = it.inc;
						tbl_sus_since[i] = (it.status == ST_SUS && sus_on) ? it.period : '0;
						tbl_dead_since[i] = '0;
						r.changed = 1'b1;
						r.marked = 1'b1;
					end
				end else if (it.status == ST_ALIVE) begin
					if ((cs == ST_ALIVE || (cs == ST_SUS && sus_on)) && ci < it.inc) begin
						tbl_status[i] = ST_ALIVE;
						tbl_inc[i] = it.inc;
						r.changed = 1'b1;
						r.marked = 1'b1;
					end
				end else if (it.status == ST_DEAD) begin
					if (cs != ST_DEAD) begin
						tbl_status[i] = ST_DEAD;
						tbl_dead_since[i] = it.period;
						r.changed = 1'b1;
						r.marked = 1'b1;
						r.self_dead = (it.idx == cfg_self);
					end
				end else if (it.status == ST_SUS && sus_on) begin
					if (it.idx == cfg_self) begin
						// Refutation: bump the own incarnation unless it is saturated.
						if (ci == it.inc && ci != '1)
							tbl_inc[i] = ci + 32'd1;
						r.changed = 1'b1;
						r.marked = 1'b1;
						r.refuted = 1'b1;
					end else if (cs == ST_SUS && ci < it.inc) begin
						tbl_inc[i] = it.inc;
						tbl_sus_since[i] = it.period;
						r.changed = 1'b1;
						r.marked = 1'b1;
					end else if (cs == ST_ALIVE && ci <= it.inc) begin
						tbl_status[i] = ST_SUS;
						tbl_inc[i] = it.inc;
						tbl_sus_since[i] = it.period;
						r.changed = 1'b1;
						r.marked = 1'b1;
					end
				end
			end
			MODE_PING: begin
				if (tbl_valid[i] && cs != ST_DEAD) begin
					if (cs == ST_ALIVE && sus_on) begin
						tbl_status[i] = ST_SUS;
						tbl_sus_since[i] = it.period;
						r.changed = 1'b1;
					end else if (!sus_on) begin
						tbl_status[i] = ST_DEAD;
						tbl_dead_since[i] = it.period;
						r.changed = 1'b1;
					end
					r.marked = 1'b1;
				end
			end
			MODE_LEAVE: begin
				if (tbl_valid[i]) begin
					tbl_status[i] = ST_DEAD;
					tbl_dead_since[i] = it.period;
					r.changed = 1'b1;
					r.marked = 1'b1;
				end
			end
			default: ;
		endcase
		if (r.marked)
			tbl_mark[i] = 1'b1;
		r.valid = tbl_valid[i];
		r.status = tbl_status[i];
		r.inc = tbl_inc[i];
		return r;
	endfunction

	function automatic gossip_item_t make_item(input logic [1:0] m, input logic [3:0] idx,
			input logic [1:0] st, input logic [31:0] inc, input logic [31:0] per);
		gossip_item_t it;
		it.mode = m;
		it.idx = idx;
		it.status = st;
		it.inc = inc;
		it.period = per;
		return it;
	endfunction

	// Mostly well-formed gossip whose incarnations track each entry, plus rare
	// kills (kill is in parts per thousand), unknown codes and full-range values.
	function automatic gossip_item_t random_item(input logic [3:0] self_idx, input int kill);
		gossip_item_t it;
		int pick;
		pick = $urandom_range(0, 999);
		if (pick < 20)
			it.mode = MODE_UNUSED;
		else if (pick < 20 + kill)
			it.mode = MODE_LEAVE;
		else if (pick < 170 + kill)
			it.mode = MODE_PING;
		else
			it.mode = MODE_MERGE;
		it.idx = ($urandom_range(0, 3) == 0) ? self_idx : 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 999);
		if (pick < 20)
			it.status = ST_UNKNOWN;
		else if (pick < 20 + kill)
			it.status = ST_DEAD;
		else if (pick < 500)
			it.status = ST_ALIVE;
		else
			it.status = ST_SUS;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			it.inc = $urandom;
		else if (pick < 6)
			it.inc = 32'hFFFF_FFFF - $urandom_range(0, 2);
		else if (gen_inc[it.idx] < 32'd2)
			it.inc = $urandom_range(0, 3);
		else
			it.inc = gen_inc[it.idx] + $urandom_range(0, 3) - 32'd2;
		if (it.mode == MODE_MERGE)
			gen_inc[it.idx] = it.inc;
		if ($urandom_range(0, 24) == 0) begin
			it.period = $urandom;
		end else begin
			gen_period = gen_period + $urandom_range(0, 2);
			it.period = gen_period;
		end
		return it;
	endfunction

	task automatic offer(input gossip_item_t it);
		gossip_q.insert(gossip_q.size(), it);
		queued_count++;
	endtask

	task automatic offer_random(input int n, input int kill);
		for (int k = 0; k < n; k++)
			offer(random_item(cfg_self, kill));
	endtask

	// Waits until every offered item has been taken and every outcome has come back.
	task automatic wait_idle();
		while (accepted_count != queued_count || outcome_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == CFG_SELF_INDEX)
			cfg_self = value[3:0];
		else
			cfg_suspicion = value[0];
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Sender: holds each item until its transfer, then waits a drawn gap.
	always @(negedge clk) begin : sender
		gossip_item_t cur;
		static int gap_left = 0;
		static logic tx_calm = 1'b0;
		if (arst_n && !(item_valid && !item_fire)) begin
			if (gap_left != 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (gossip_q.size() != 0) begin
				cur = gossip_q.pop_front();
				mode <= cur.mode;
				member_index <= cur.idx;
				entry_status <= cur.status;
				entry_incarnation <= cur.inc;
				current_period <= cur.period;
				item_valid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					tx_calm = !tx_calm;
				gap_left = tx_calm ? 0 : int'($urandom_range(0, 16));
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: after each transfer draws a stall, and obeys the long hold-off.
	always @(negedge clk) begin : receiver
		static int rx_wait = 0;
		static logic rx_calm = 1'b0;
		if (arst_n) begin
			if (result_fire) begin
				if ($urandom_range(0, 39) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : int'($urandom_range(0, 16));
			end
			if (hold_left != 0) begin
				result_ready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off, counted here once requested.
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left = LONG_HOLD;
			hold_done = 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
		end
	end

	// Monitor: checks each result transfer, then predicts for each item transfer.
	always @(posedge clk) begin : monitor
		entry_outcome_t want;
		item_fire <= item_valid && item_ready;
		result_fire <= result_valid && result_ready;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result transfer with no outcome pending");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("entry_changed", 32'(want.changed), 32'(entry_changed));
					check_field("new_valid", 32'(want.valid), 32'(new_valid));
					check_field("new_status", 32'(want.status), 32'(new_status));
					check_field("new_incarnation", want.inc, new_incarnation);
					check_field("marked_for_send", 32'(want.marked), 32'(marked_for_send));
					check_field("self_refuted", 32'(want.refuted), 32'(self_refuted));
					check_field("self_declared_dead", 32'(want.self_dead),
						32'(self_declared_dead));
					results_checked++;
					writes_seen += int'(want.changed);
					refutes_seen += int'(want.refuted);
					self_deaths_seen += int'(want.self_dead);
				end
			end
			if (item_valid && item_ready) begin
				outcome_q.insert(outcome_q.size(), merge_membership(make_item(mode,
					member_index, entry_status, entry_incarnation, current_period)));
				accepted_count++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with reset settings: this node is member 0, suspicion on.
		offer(make_item(MODE_MERGE, 4'd1, ST_ALIVE, 32'd5, 32'd0));
		offer(make_item(MODE_MERGE, 4'd2, ST_SUS, 32'd3, 32'd100));
		offer(make_item(MODE_MERGE, 4'd3, ST_DEAD, 32'd1, 32'd101));
		offer(make_item(MODE_MERGE, 4'd1, ST_UNKNOWN, 32'd9, 32'd102));
		offer(make_item(MODE_MERGE, 4'd1, ST_ALIVE, 32'd5, 32'd103));
		offer(make_item(MODE_MERGE, 4'd1, ST_ALIVE, 32'd7, 32'd104));
		offer(make_item(MODE_MERGE, 4'd1, ST_SUS, 32'd6, 32'd105));
		offer(make_item(MODE_MERGE, 4'd1, ST_SUS, 32'd7, 32'd106));
		offer(make_item(MODE_MERGE, 4'd1, ST_SUS, 32'd9, 32'd107));
		offer(make_item(MODE_MERGE, 4'd1, ST_ALIVE, 32'd10, 32'd108));
		// Own entry: join, refute with and without bump, then saturation.
		offer(make_item(MODE_MERGE, 4'd0, ST_ALIVE, 32'd8, 32'd109));
		offer(make_item(MODE_MERGE, 4'd0, ST_SUS, 32'd8, 32'd110));
		offer(make_item(MODE_MERGE, 4'd0, ST_SUS, 32'd3, 32'd111));
		offer(make_item(MODE_MERGE, 4'd0, ST_ALIVE, 32'hFFFF_FFFF, 32'd112));
		offer(make_item(MODE_MERGE, 4'd0, ST_SUS, 32'hFFFF_FFFF, 32'd113));
		// Ping timeouts and leaves, including invalid and dead targets.
		offer(make_item(MODE_MERGE, 4'd4, ST_ALIVE, 32'd0, 32'd114));
		offer(make_item(MODE_PING, 4'd4, ST_UNKNOWN, 32'hFFFF_FFFF, 32'd115));
		offer(make_item(MODE_PING, 4'd4, ST_ALIVE, 32'd0, 32'd116));
		offer(make_item(MODE_PING, 4'd15, ST_DEAD, 32'd0, 32'd117));
		offer(make_item(MODE_LEAVE, 4'd4, ST_SUS, 32'd0, 32'd118));
		offer(make_item(MODE_LEAVE, 4'd4, ST_ALIVE, 32'd0, 32'hFFFF_FFFF));
		offer(make_item(MODE_PING, 4'd4, ST_ALIVE, 32'd0, 32'd120));
		offer(make_item(MODE_MERGE, 4'd4, ST_ALIVE, 32'd100, 32'd121));
		offer(make_item(MODE_UNUSED, 4'd1, ST_ALIVE, 32'd50, 32'd122));
		offer(make_item(MODE_MERGE, 4'd0, ST_DEAD, 32'd0, 32'd123));
		offer(make_item(MODE_LEAVE, 4'd15, ST_ALIVE, 32'd0, 32'd124));
		wait_idle();

		write_reg(CFG_SELF_INDEX, 32'd5);
		write_reg(CFG_SUSPICION, 32'd1);
		offer_random(600, 5);
		wait_idle();

		// Long receiver hold-off while items keep coming, then a full drain
		// before the sender resumes.
		write_reg(CFG_SELF_INDEX, 32'd0);
		offer_random(250, 5);
		hold_go = 1'b1;
		wait_idle();
		offer_random(250, 5);
		wait_idle();

		write_reg(CFG_SELF_INDEX, 32'd9);
		offer_random(350, 5);
		wait_idle();

		// Suspicion off: failures are declared directly.
		write_reg(CFG_SELF_INDEX, 32'd15);
		write_reg(CFG_SUSPICION, 32'd0);
		offer_random(200, 10);
		wait_idle();
		repeat (8) @(negedge clk);

		$display("tb: %0d items over five settings, %0d results checked", accepted_count,
			results_checked);
		$display("tb: %0d entry writes, %0d refutations, %0d self deaths seen", writes_seen,
			refutes_seen, self_deaths_seen);
		if (fail_count == 0 && outcome_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
